FILE: sv/two_class_priority_fifo_dedup_assert.svh
// Assertion macros for the two-class priority FIFO block.
`ifndef TWO_CLASS_PRIORITY_FIFO_DEDUP_ASSERT_SVH
`define TWO_CLASS_PRIORITY_FIFO_DEDUP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCPFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCPFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tcpfd_pkg.sv
// Shared types and constants of the two-class priority FIFO block.
package tcpfd_pkg;

  localparam int PAY_W  = 32;
  localparam int ID_BITS = 7;
  localparam int STAT_W = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS,
    ST_POP,
    ST_HEAD
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic              clr_step;
    logic              accept;
    logic              ins_commit;
    logic              pop_commit;
    logic              head_load;
    logic              res_load;
    logic              res_pop;
    logic [STAT_W-1:0] res_status;
  } dp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic in_range;
    logic hit;
    logic any_queued;
    logic pop_last;
    logic clr_last;
  } dp_stat_t;

endpackage

FILE: sv/two_class_priority_fifo_dedup.sv
// Top level of the two-class strict-priority FIFO with id dedup.
// Usage:
//   A command word is taken at a rising edge with start high and busy low.
//   command_i 0 inserts payload_i under item_id_i into class category_i
//   (1 high, 0 low); command_i 1 removes the next entry, class 1 first.
//   An insert whose id is already queued or out of range is dropped (status 1);
//   a remove with both queues empty reports status 2.
//   One result word follows each command, shown for one cycle with done_o
//   high. The receiver cannot stall: it must take the word in that cycle.
//   head_valid_o, head_payload_o and all_empty_o show the queue state after
//   the step and stay valid until the next command.
// Steps: an out-of-range insert or an empty remove answers from ST_IDLE; any
//   other insert (duplicates too) passes ST_INS, a remove that empties its
//   class ST_POP, other removes ST_POP then ST_HEAD. Each step waits on the
//   registered read of the id, link and payload RAMs; busy stays high meanwhile.
// Throughput: busy is low in the done_o cycle, so the next word can be taken at
//   the edge that ends it.
// Reset: after rst_ni rises, busy stays high for ID_COUNT cycles while the id
//   bitmap RAM is cleared one entry a cycle; both queues start empty.
module two_class_priority_fifo_dedup import tcpfd_pkg::*; #(
  parameter int ID_COUNT     = 128,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               command_i,
  input  logic [PAY_W-1:0]   payload_i,
  input  logic               category_i,
  input  logic [ID_BITS-1:0] item_id_i,
  output logic               done_o,
  output logic [STAT_W-1:0]  status_o,
  output logic [PAY_W-1:0]   popped_payload_o,
  output logic [ID_BITS-1:0] popped_id_o,
  output logic               head_valid_o,
  output logic [PAY_W-1:0]   head_payload_o,
  output logic               all_empty_o
);

`include "two_class_priority_fifo_dedup_assert.svh"

  dp_ctl_t  ctl;
  dp_stat_t stat;

  tcpfd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (stat),
    .ctl_o     (ctl),
    .busy      (busy),
    .done_o    (done_o)
  );

  tcpfd_dp #(
    .ID_COUNT     (ID_COUNT),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .payload_i        (payload_i),
    .category_i       (category_i),
    .item_id_i        (item_id_i),
    .ctl_i            (ctl),
    .stat_o           (stat),
    .status_o         (status_o),
    .popped_payload_o (popped_payload_o),
    .popped_id_o      (popped_id_o),
    .head_valid_o     (head_valid_o),
    .head_payload_o   (head_payload_o),
    .all_empty_o      (all_empty_o)
  );

  // a result word is only delivered while the sequence is back in idle
  `TCPFD_ASSERT_NOW(a_done_idle, done_o, !busy, "result strobe while busy")
  // an accepted command either answers at once or keeps the block busy
  `TCPFD_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_o, "command lost")
  // rejected or empty results carry no popped entry
  `TCPFD_ASSERT_NOW(a_no_pop_on_fail, done_o && status_o != STAT_DONE,
                    popped_id_o == '0 && popped_payload_o == '0, "stale popped entry")
  // an empty remove leaves both queues empty
  `TCPFD_ASSERT_NOW(a_empty_consistent, done_o && status_o == STAT_EMPTY,
                    all_empty_o && !head_valid_o, "empty status with queued entry")

endmodule

FILE: sv/tcpfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcpfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tcpfd_ctrl.sv
// Sequencer: clear pass, insert and remove steps, result strobe.
module tcpfd_ctrl import tcpfd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     command_i,
  input  dp_stat_t stat_i,
  output dp_ctl_t  ctl_o,
  output logic     busy,
  output logic     done_o
);

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (command_i == CMD_INSERT) begin
            if (stat_i.in_range) state_d = ST_INS;
          end else if (stat_i.any_queued) begin
            state_d = ST_POP;
          end
        end
      end
      ST_INS:  state_d = ST_IDLE;
      ST_POP:  state_d = stat_i.pop_last ? ST_IDLE : ST_HEAD;
      ST_HEAD: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    ctl_o.res_status = STAT_DONE;
    case (state_q)
      ST_CLEAR: ctl_o.clr_step = 1'b1;
      ST_IDLE: begin
        if (start) begin
          ctl_o.accept = 1'b1;
          if (command_i == CMD_INSERT) begin
            if (!stat_i.in_range) begin
              ctl_o.res_load   = 1'b1;
              ctl_o.res_status = STAT_DUP;
            end
          end else if (!stat_i.any_queued) begin
            ctl_o.res_load   = 1'b1;
            ctl_o.res_status = STAT_EMPTY;
          end
        end
      end
      ST_INS: begin
        ctl_o.res_load = 1'b1;
        if (stat_i.hit) begin
          ctl_o.res_status = STAT_DUP;
        end else begin
          ctl_o.ins_commit = 1'b1;
        end
      end
      ST_POP: begin
        ctl_o.pop_commit = 1'b1;
        if (stat_i.pop_last) begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_pop  = 1'b1;
        end
      end
      ST_HEAD: begin
        ctl_o.head_load = 1'b1;
        ctl_o.res_load  = 1'b1;
        ctl_o.res_pop   = 1'b1;
      end
      default: ;
    endcase
  end

  assign done_d = ctl_o.res_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

FILE: sv/tcpfd_dp.sv
// Datapath: id bitmap, link and payload RAMs, per-class head/tail registers.
module tcpfd_dp import tcpfd_pkg::*; #(
  parameter int ID_COUNT     = 128,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [PAY_W-1:0]   payload_i,
  input  logic               category_i,
  input  logic [ID_BITS-1:0] item_id_i,
  input  dp_ctl_t            ctl_i,
  output dp_stat_t           stat_o,
  output logic [STAT_W-1:0]  status_o,
  output logic [PAY_W-1:0]   popped_payload_o,
  output logic [ID_BITS-1:0] popped_id_o,
  output logic               head_valid_o,
  output logic [PAY_W-1:0]   head_payload_o,
  output logic               all_empty_o
);

  localparam int ID_W = $clog2(ID_COUNT);
  localparam int CW   = ((ID_W > ID_BITS) ? ID_W : ID_BITS) + 1;
  localparam int PB   = PAYLOAD_BITS;

  logic [CW-1:0]   id_ext;
  logic [ID_W-1:0] id_idx;

  // latched command fields
  logic [ID_W-1:0] id_q;
  logic [PB-1:0]   pay_q;
  logic            cls_q;
  logic            pop_cls_q;

  logic [1:0]      nonempty_q, nonempty_d;
  logic [ID_W-1:0] head_q [2];
  logic [ID_W-1:0] head_d [2];
  logic [ID_W-1:0] tail_q [2];
  logic [ID_W-1:0] tail_d [2];
  logic [PB-1:0]   head_pay_q [2];
  logic [PB-1:0]   head_pay_d [2];
  logic [ID_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [ID_W-1:0] pop_id_q, pop_id_d;
  logic [PB-1:0]   pop_pay_q, pop_pay_d;

  logic            srv;
  logic            any;
  logic [ID_W-1:0] hd;

  logic            pres_we, pres_wdata, pres_rdata;
  logic [ID_W-1:0] pres_waddr;
  logic            link_we;
  logic [ID_W-1:0] link_rdata;
  logic [PB-1:0]   pay_rdata;

  assign id_ext = CW'(item_id_i);
  assign id_idx = id_ext[ID_W-1:0];

  assign srv = nonempty_q[1];
  assign any = |nonempty_q;
  assign hd  = head_q[srv];

  always_comb begin
    pres_we    = 1'b0;
    pres_waddr = clr_cnt_q;
    pres_wdata = 1'b0;
    if (ctl_i.clr_step) begin
      pres_we = 1'b1;
    end else if (ctl_i.ins_commit) begin
      pres_we    = 1'b1;
      pres_waddr = id_q;
      pres_wdata = 1'b1;
    end else if (ctl_i.pop_commit) begin
      pres_we    = 1'b1;
      pres_waddr = hd;
    end
  end

  assign link_we = ctl_i.ins_commit & nonempty_q[cls_q];

  // addresses run free; bitmap/link data feed ST_INS/ST_POP, payload ST_HEAD
  tcpfd_ram #(.WIDTH(1), .DEPTH(ID_COUNT)) u_pres (
    .clk_i   (clk_i),
    .we_i    (pres_we),
    .waddr_i (pres_waddr),
    .wdata_i (pres_wdata),
    .raddr_i (id_idx),
    .rdata_o (pres_rdata)
  );

  tcpfd_ram #(.WIDTH(ID_W), .DEPTH(ID_COUNT)) u_link (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (tail_q[cls_q]),
    .wdata_i (id_q),
    .raddr_i (hd),
    .rdata_o (link_rdata)
  );

  tcpfd_ram #(.WIDTH(PB), .DEPTH(ID_COUNT)) u_pay (
    .clk_i   (clk_i),
    .we_i    (ctl_i.ins_commit),
    .waddr_i (id_q),
    .wdata_i (pay_q),
    .raddr_i (link_rdata),
    .rdata_o (pay_rdata)
  );

  always_comb begin
    nonempty_d = nonempty_q;
    head_d     = head_q;
    tail_d     = tail_q;
    head_pay_d = head_pay_q;
    clr_cnt_d  = clr_cnt_q;
    status_d   = status_q;
    pop_id_d   = pop_id_q;
    pop_pay_d  = pop_pay_q;

    if (ctl_i.clr_step) clr_cnt_d = clr_cnt_q + ID_W'(1);

    if (ctl_i.ins_commit) begin
      tail_d[cls_q] = id_q;
      if (!nonempty_q[cls_q]) begin
        head_d[cls_q]     = id_q;
        head_pay_d[cls_q] = pay_q;
        nonempty_d[cls_q] = 1'b1;
      end
    end

    if (ctl_i.pop_commit) begin
      pop_id_d  = hd;
      pop_pay_d = head_pay_q[srv];
      if (hd == tail_q[srv]) begin
        nonempty_d[srv] = 1'b0;
      end else begin
        head_d[srv] = link_rdata;
      end
    end

    if (ctl_i.head_load) head_pay_d[pop_cls_q] = pay_rdata;

    if (ctl_i.res_load) begin
      status_d = ctl_i.res_status;
      if (!ctl_i.res_pop) begin
        pop_id_d  = '0;
        pop_pay_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= '0;
      head_q     <= '{default: '0};
      tail_q     <= '{default: '0};
      clr_cnt_q  <= '0;
      status_q   <= STAT_DONE;
      pop_id_q   <= '0;
      pop_pay_q  <= '0;
    end else begin
      nonempty_q <= nonempty_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      clr_cnt_q  <= clr_cnt_d;
      status_q   <= status_d;
      pop_id_q   <= pop_id_d;
      pop_pay_q  <= pop_pay_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_pay_q <= head_pay_d;
    if (ctl_i.accept) begin
      id_q  <= id_idx;
      pay_q <= PB'(payload_i);
      cls_q <= category_i;
    end
    if (ctl_i.pop_commit) pop_cls_q <= srv;
  end

  assign stat_o.in_range   = (id_ext < CW'(ID_COUNT));
  assign stat_o.hit        = pres_rdata;
  assign stat_o.any_queued = any;
  assign stat_o.pop_last   = (hd == tail_q[srv]);
  assign stat_o.clr_last   = (clr_cnt_q == ID_W'(ID_COUNT - 1));

  assign status_o         = status_q;
  assign popped_payload_o = PAY_W'(pop_pay_q);
  assign popped_id_o      = ID_BITS'(pop_id_q);
  assign head_valid_o     = any;
  assign head_payload_o   = any ? PAY_W'(head_pay_q[srv]) : '0;
  assign all_empty_o      = ~any;

endmodule

FILE: tb/sv/two_class_priority_fifo_dedup_tb.sv
// Self-checking testbench for the two-class priority FIFO with id dedup.
module two_class_priority_fifo_dedup_tb;
  import tcpfd_pkg::*;

  localparam int   IDS      = 128;
  localparam logic CLS_LOW  = 1'b0;
  localparam logic CLS_HIGH = 1'b1;
  localparam logic [PAY_W-1:0] PAY_ONES = '1;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [PAY_W-1:0]   popped_payload;
    logic [ID_BITS-1:0] popped_id;
    logic               head_valid;
    logic [PAY_W-1:0]   head_payload;
    logic               all_empty;
  } fifo_result_t;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start      = 1'b0;
  logic               command_i  = CMD_INSERT;
  logic [PAY_W-1:0]   payload_i  = '0;
  logic               category_i = CLS_LOW;
  logic [ID_BITS-1:0] item_id_i  = '0;
  logic               busy;
  logic               done_o;
  logic [STAT_W-1:0]  status_o;
  logic [PAY_W-1:0]   popped_payload_o;
  logic [ID_BITS-1:0] popped_id_o;
  logic               head_valid_o;
  logic [PAY_W-1:0]   head_payload_o;
  logic               all_empty_o;

  // shadow copy of the queues, indexed by id like the block
  bit                 id_queued [IDS];
  bit [ID_BITS-1:0]   link_to   [IDS];
  bit [PAY_W-1:0]     pay_mem   [IDS];
  bit [ID_BITS-1:0]   head_id   [2];
  bit [ID_BITS-1:0]   tail_id   [2];
  bit                 class_has [2];

  fifo_result_t pending_results [$];
  int           fail_count   = 0;
  int           send_gap_pct = 0;

  two_class_priority_fifo_dedup uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .command_i        (command_i),
    .payload_i        (payload_i),
    .category_i       (category_i),
    .item_id_i        (item_id_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .popped_payload_o (popped_payload_o),
    .popped_id_o      (popped_id_o),
    .head_valid_o     (head_valid_o),
    .head_payload_o   (head_payload_o),
    .all_empty_o      (all_empty_o)
  );

  always #2 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("two_class_priority_fifo_dedup regression: fail");
    $finish;
  end

  // Updates the shadow queues for one command and returns the word it yields.
  function automatic fifo_result_t apply_command(input logic cmd, input logic [PAY_W-1:0] pay,
                                                 input logic cls,
                                                 input logic [ID_BITS-1:0] id);
    fifo_result_t r;
    int           srv;
    bit [ID_BITS-1:0] h;
    r.status         = STAT_DONE;
    r.popped_payload = '0;
    r.popped_id      = '0;
    if (cmd == CMD_INSERT) begin
      if (id_queued[id]) begin
        r.status = STAT_DUP;
      end else begin
        pay_mem[id] = pay;
        link_to[id] = '0;
        if (class_has[cls]) begin
          link_to[tail_id[cls]] = id;
        end else begin
          head_id[cls]   = id;
          class_has[cls] = 1'b1;
        end
        tail_id[cls]  = id;
        id_queued[id] = 1'b1;
      end
    end else if (!class_has[CLS_LOW] && !class_has[CLS_HIGH]) begin
      r.status = STAT_EMPTY;
    end else begin
      srv = class_has[CLS_HIGH] ? 1 : 0;
      h   = head_id[srv];
      r.popped_payload = pay_mem[h];
      r.popped_id      = h;
      if (h == tail_id[srv]) class_has[srv] = 1'b0;
      else head_id[srv] = link_to[h];
      id_queued[h] = 1'b0;
    end
    r.head_valid   = class_has[CLS_LOW] | class_has[CLS_HIGH];
    r.all_empty    = !r.head_valid;
    srv            = class_has[CLS_HIGH] ? 1 : 0;
    r.head_payload = r.head_valid ? pay_mem[head_id[srv]] : '0;
    return r;
  endfunction

  // Free id when there is one, else an id that is queued (a duplicate).
  function automatic logic [ID_BITS-1:0] free_id();
    int base;
    int idx;
    base = $urandom_range(0, IDS - 1);
    for (int i = 0; i < IDS; i++) begin
      idx = (base + i) % IDS;
      if (!id_queued[idx]) return ID_BITS'(idx);
    end
    return ID_BITS'(base);
  endfunction

  // Presents one command word and returns at the edge that takes it.
  task automatic send_word(input logic cmd, input logic [PAY_W-1:0] pay, input logic cls,
                           input logic [ID_BITS-1:0] id);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    command_i  <= cmd;
    payload_i  <= pay;
    category_i <= cls;
    item_id_i  <= id;
    // busy is stable from the falling edge up to the next rising edge
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    pending_results.push_back(apply_command(cmd, pay, cls, id));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [PAY_W-1:0] want,
                             input logic [PAY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk_i) begin : result_check
    fifo_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result word with no command outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", PAY_W'(want.status), PAY_W'(status_o));
        check_field("popped_payload", want.popped_payload, popped_payload_o);
        check_field("popped_id", PAY_W'(want.popped_id), PAY_W'(popped_id_o));
        check_field("head_valid", PAY_W'(want.head_valid), PAY_W'(head_valid_o));
        check_field("head_payload", want.head_payload, head_payload_o);
        check_field("all_empty", PAY_W'(want.all_empty), PAY_W'(all_empty_o));
      end
    end
  end

  // Fields other than the command are don't-care on a remove; drive junk.
  task automatic test_remove_on_empty();
    send_word(CMD_REMOVE, PAY_ONES, CLS_HIGH, 7'd127);
  endtask

  task automatic test_priority_and_duplicates();
    send_word(CMD_INSERT, '0, CLS_LOW, 7'd0);
    send_word(CMD_INSERT, PAY_ONES, CLS_LOW, 7'd127);
    send_word(CMD_INSERT, 32'hA5A5_A5A5, CLS_HIGH, 7'd64);
    send_word(CMD_INSERT, 32'h5A5A_5A5A, CLS_HIGH, 7'd1);
    // same id in the other class is still a duplicate
    send_word(CMD_INSERT, 32'h1234_5678, CLS_HIGH, 7'd0);
    send_word(CMD_INSERT, 32'h0BAD_F00D, CLS_LOW, 7'd127);
    send_word(CMD_INSERT, 32'hFFFF_0000, CLS_LOW, 7'd64);
    repeat (5) send_word(CMD_REMOVE, '0, CLS_LOW, '0);
  endtask

  task automatic test_id_reuse();
    send_word(CMD_INSERT, 32'h0000_0003, CLS_HIGH, 7'd3);
    send_word(CMD_REMOVE, 32'hDEAD_BEEF, CLS_LOW, 7'd3);
    send_word(CMD_INSERT, 32'h8000_0000, CLS_HIGH, 7'd3);
    send_word(CMD_INSERT, 32'h7FFF_FFFF, CLS_LOW, 7'd3);
    send_word(CMD_INSERT, 32'h0000_0009, CLS_LOW, 7'd9);
    repeat (2) send_word(CMD_REMOVE, '0, CLS_HIGH, '1);
  endtask

  // tail link written while the class already has a head
  task automatic test_single_class_link();
    send_word(CMD_INSERT, 32'h0000_0010, CLS_LOW, 7'd10);
    send_word(CMD_INSERT, 32'h0000_0011, CLS_LOW, 7'd11);
    send_word(CMD_REMOVE, '0, CLS_LOW, '0);
    send_word(CMD_INSERT, 32'h0000_0012, CLS_LOW, 7'd12);
    repeat (2) send_word(CMD_REMOVE, '0, CLS_LOW, '0);
  endtask

  // Bursts with their own insert and class mix, so queues fill up and drain.
  task automatic run_random(input int n_words, input int gap_pct);
    int insert_pct;
    int high_pct;
    int burst_left;
    logic [PAY_W-1:0]   pay;
    logic [ID_BITS-1:0] id;
    send_gap_pct = gap_pct;
    burst_left   = 0;
    insert_pct   = 50;
    high_pct     = 50;
    for (int k = 0; k < n_words; k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(16, 64);
        case ($urandom_range(0, 3))
          0:       insert_pct = 10;
          1:       insert_pct = 35;
          2:       insert_pct = 65;
          default: insert_pct = 90;
        endcase
        case ($urandom_range(0, 2))
          0:       high_pct = 10;
          1:       high_pct = 50;
          default: high_pct = 90;
        endcase
      end
      burst_left--;
      case ($urandom_range(0, 7))
        0:       pay = '0;
        1:       pay = PAY_ONES;
        default: pay = $urandom;
      endcase
      if ($urandom_range(0, 99) < insert_pct) begin
        id = ($urandom_range(0, 99) < 85) ? free_id() : ID_BITS'($urandom_range(0, IDS - 1));
        send_word(CMD_INSERT, pay,
                  ($urandom_range(0, 99) < high_pct) ? CLS_HIGH : CLS_LOW, id);
      end else begin
        send_word(CMD_REMOVE, pay, 1'($urandom_range(0, 1)), ID_BITS'($urandom));
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random(620, 33);
    wait_drained();
    run_random(620, 51);
    run_random(620, 0);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_remove_on_empty();
    test_priority_and_duplicates();
    test_id_reuse();
    test_single_class_link();
    wait_drained();
    test_random_traffic();
    wait_drained();
    if (fail_count == 0) begin
      $display("two_class_priority_fifo_dedup regression: pass");
    end else begin
      $display("two_class_priority_fifo_dedup regression: fail");
    end
    $finish;
  end

endmodule
